// ----- rtl/u8u16_pkg.sv -----
// shared types and constants for the utf-8 to utf-16 decoder
package u8u16_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_UNIT    = 2'd0,
		ST_END     = 2'd1,
		ST_INVALID = 2'd2,
		ST_LONG    = 2'd3
	} status_t;

	// one result word
	typedef struct packed {
		logic [15:0] code_unit;
		status_t     status;
		logic        last;
	} result_t;

	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
	localparam logic [9:0]  SURR_MASK    = 10'h3FF;
	localparam logic [7:0]  LEAD2_MASK   = 8'hE0;
	localparam logic [7:0]  LEAD2_CODE   = 8'hC0;
	localparam logic [7:0]  LEAD3_MASK   = 8'hF0;
	localparam logic [7:0]  LEAD3_CODE   = 8'hE0;
	localparam logic [7:0]  LEAD4_MASK   = 8'hF8;
	localparam logic [7:0]  LEAD4_CODE   = 8'hF0;
	localparam logic [7:0]  LEAD5_MASK   = 8'hFC;
	localparam logic [7:0]  LEAD5_CODE   = 8'hF8;
	localparam logic [7:0]  LEAD6_MASK   = 8'hFE;
	localparam logic [7:0]  LEAD6_CODE   = 8'hFC;
	localparam logic [5:0]  CONT_MASK    = 6'h3F;
	localparam logic [20:0] PLANE1_BASE  = 21'h010000;
	localparam logic [20:0] UNICODE_MAX  = 21'h10FFFF;

endpackage

// ----- rtl/u8u16_byte_if.sv -----
// input channel carrying one utf-8 byte per word
interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// ----- rtl/u8u16_unit_if.sv -----
// output channel carrying one utf-16 result per word
interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, output code_unit, output status, output last, input ready);
	modport sink (input valid, input code_unit, input status, input last, output ready);
endinterface

// ----- rtl/utf8_to_utf16_decoder.sv -----
// utf-8 byte stream to utf-16 code unit decoder
//
// Channels: utf8 brings one byte per word, a zero byte ends the string.
// utf16 returns results: a code unit (status 0), end of string (1),
// invalid byte or value (2) or a skipped five/six-byte form (3); last
// marks the final result caused by one input byte.
// A byte is registered at the input and decoded from that register, and
// its results are written into a two-entry output queue that feeds utf16.
// Throughput: one byte per cycle. A surrogate pair gives two output
// words; the decode stage waits only while the output queue lacks room
// for the results of the byte it holds.
// Reset clears the decode state, the input valid flag and the queue count.
// When the receiver stalls, the queue fills, then the input register
// holds its byte and utf8.ready drops; no word is lost or repeated.
module utf8_to_utf16_decoder
	import u8u16_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	u8u16_byte_if.sink          utf8,
	u8u16_unit_if.source        utf16
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// decode state
	logic [2:0]  pend_q;
	logic [20:0] acc_q;
	logic        skip_q;
	logic [2:0]  seq_q;

	// output queue
	result_t     slot0_q, slot1_q;
	logic [1:0]  cnt_q;

	// decode results
	logic [2:0]  pend_d;
	logic [20:0] acc_d;
	logic        skip_d;
	logic [2:0]  seq_d;
	logic [1:0]  n_res;
	result_t     r0, r1;
	logic [20:0] acc_sh;
	logic [19:0] v_off;
	logic [2:0]  pend_m1;

	logic        pop, adv;
	logic [1:0]  free_slots, rem_cnt;
	result_t     nxt0, nxt1;

	assign acc_sh  = {acc_q[14:0], byte_s1[5:0] & CONT_MASK};
	assign v_off   = 20'(acc_sh - PLANE1_BASE);
	assign pend_m1 = pend_q - 3'd1;

	// decode of the held byte
	always_comb begin
		pend_d = pend_q;
		acc_d  = acc_q;
		skip_d = skip_q;
		seq_d  = seq_q;
		n_res  = 2'd0;
		r0     = '{code_unit: 16'd0, status: ST_INVALID, last: 1'b1};
		r1     = '{code_unit: 16'd0, status: ST_UNIT, last: 1'b1};
		priority if (byte_s1 == 8'd0) begin
			pend_d = 3'd0;
			acc_d  = 21'd0;
			skip_d = 1'b0;
			seq_d  = 3'd0;
			n_res  = 2'd1;
			r0.status = ST_END;
		end else if (skip_q) begin
			if (pend_q != 3'd0) begin
				pend_d = pend_m1;
			end
			if (pend_q <= 3'd1) begin
				skip_d = 1'b0;
			end
		end else if (pend_q != 3'd0) begin
			acc_d  = acc_sh;
			pend_d = pend_m1;
			if (pend_m1 == 3'd0) begin
				seq_d = 3'd0;
				acc_d = 21'd0;
				if (seq_q == 3'd4) begin
					if (acc_sh < PLANE1_BASE || acc_sh > UNICODE_MAX) begin
						n_res = 2'd1;
					end else begin
						n_res = 2'd2;
						r0 = '{code_unit: HI_SURR_BASE + {6'd0, v_off[19:10]},
							status: ST_UNIT, last: 1'b0};
						r1 = '{code_unit: LO_SURR_BASE + {6'd0, v_off[9:0] & SURR_MASK},
							status: ST_UNIT, last: 1'b1};
					end
				end else begin
					n_res = 2'd1;
					r0 = '{code_unit: acc_sh[15:0], status: ST_UNIT, last: 1'b1};
				end
			end
		end else if (byte_s1[7] == 1'b0) begin
			n_res = 2'd1;
			r0 = '{code_unit: {8'd0, byte_s1}, status: ST_UNIT, last: 1'b1};
		end else if ((byte_s1 & LEAD2_MASK) == LEAD2_CODE) begin
			seq_d  = 3'd2;
			pend_d = 3'd1;
			acc_d  = {16'd0, byte_s1[4:0]};
		end else if ((byte_s1 & LEAD3_MASK) == LEAD3_CODE) begin
			seq_d  = 3'd3;
			pend_d = 3'd2;
			acc_d  = {17'd0, byte_s1[3:0]};
		end else if ((byte_s1 & LEAD4_MASK) == LEAD4_CODE) begin
			seq_d  = 3'd4;
			pend_d = 3'd3;
			acc_d  = {18'd0, byte_s1[2:0]};
		end else if ((byte_s1 & LEAD5_MASK) == LEAD5_CODE) begin
			skip_d = 1'b1;
			pend_d = 3'd4;
			n_res  = 2'd1;
			r0.status = ST_LONG;
		end else if ((byte_s1 & LEAD6_MASK) == LEAD6_CODE) begin
			skip_d = 1'b1;
			pend_d = 3'd5;
			n_res  = 2'd1;
			r0.status = ST_LONG;
		end else begin
			n_res = 2'd1;
		end
	end

	// handshake and queue room
	assign pop        = (cnt_q != 2'd0) && utf16.ready;
	assign free_slots = 2'd2 - cnt_q + {1'b0, pop};
	assign adv        = valid_s1 && (free_slots >= n_res);
	assign utf8.ready = !valid_s1 || adv;
	assign rem_cnt    = cnt_q - {1'b0, pop};

	// next queue contents
	always_comb begin
		nxt0 = pop ? slot1_q : slot0_q;
		nxt1 = slot1_q;
		if (adv && n_res != 2'd0) begin
			if (rem_cnt == 2'd0) begin
				nxt0 = r0;
			end else begin
				nxt1 = r0;
			end
			if (n_res == 2'd2) begin
				nxt1 = r1;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= 2'd0;
			pend_q   <= 3'd0;
			acc_q    <= 21'd0;
			skip_q   <= 1'b0;
			seq_q    <= 3'd0;
		end else begin
			if (utf8.ready) begin
				valid_s1 <= utf8.valid;
			end
			cnt_q <= rem_cnt + (adv ? n_res : 2'd0);
			if (adv) begin
				pend_q <= pend_d;
				acc_q  <= acc_d;
				skip_q <= skip_d;
				seq_q  <= seq_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (utf8.ready && utf8.valid) begin
			byte_s1 <= utf8.in_byte;
		end
		slot0_q <= nxt0;
		slot1_q <= nxt1;
	end

	assign utf16.valid     = (cnt_q != 2'd0);
	assign utf16.code_unit = slot0_q.code_unit;
	assign utf16.status    = slot0_q.status;
	assign utf16.last      = slot0_q.last;

	// queue never holds more than two results
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("output queue overfilled");

	// an open sequence always expects bytes and is not a skip
	a_seq_open: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q != 3'd0 |-> (pend_q != 3'd0 && !skip_q))
		else $error("open sequence without pending bytes");

	// a skip always has bytes left and no open sequence
	a_skip_pend: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (pend_q != 3'd0 && seq_q == 3'd0))
		else $error("skip state inconsistent");

	// non-unit results carry a zero code unit
	a_zero_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(utf16.valid && slot0_q.status != ST_UNIT) |-> slot0_q.code_unit == 16'd0)
		else $error("status word with nonzero code unit");

endmodule
